[rtl/mexp_pkg.sv]
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types and the field width constant for the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int unsigned FIELD_W = 64;

  typedef struct packed {
    logic [FIELD_W-1:0] base;
    logic [FIELD_W-1:0] exponent;
    logic [FIELD_W-1:0] modulus;
  } mexp_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] result;
    logic               bad_modulus;
  } mexp_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED,
    ST_BIT,
    ST_SQ,
    ST_ML,
    ST_DONE
  } mexp_state_t;

endpackage

[rtl/mexp_cell.sv]
// ----------------------------------------------------------------------------
// mexp_cell
// One bit of the multiplier operand chain: load or take neighbor's bit.
// ----------------------------------------------------------------------------
module mexp_cell (
  input  logic clk,
  input  logic load,
  input  logic shift,
  input  logic d_load,
  input  logic d_shift,
  output logic q
);

  logic bit_r;
  logic bit_nxt;

  always_comb begin
    bit_nxt = bit_r;
    if (load) begin
      bit_nxt = d_load;
    end else if (shift) begin
      bit_nxt = d_shift;
    end
  end

  always_ff @(posedge clk) begin
    bit_r <= bit_nxt;
  end

  assign q = bit_r;

endmodule

[rtl/mexp_modmul.sv]
// ----------------------------------------------------------------------------
// mexp_modmul
// Bit-serial modular multiplier: x*y mod m, with y shifted out of a cell chain.
// ----------------------------------------------------------------------------
module mexp_modmul #(
  parameter int unsigned WIDTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [WIDTH-1:0]   x,
  input  logic [WIDTH-1:0]   y,
  input  logic [WIDTH-1:0]   m,
  output logic               done,
  output logic [WIDTH-1:0]   prod
);

  localparam int unsigned CW = $clog2(WIDTH + 1);

  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [WIDTH-1:0] x_r, m_r;
  logic [WIDTH-1:0] ybits;
  logic [WIDTH-1:0] dbl, gap_d, gap_x, sum;

  genvar gi;
  generate
    for (gi = 0; gi < WIDTH; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        mexp_cell u_cell (
          .clk     (clk),
          .load    (start),
          .shift   (run_r),
          .d_load  (y[gi]),
          .d_shift (1'b0),
          .q       (ybits[gi])
        );
      end else begin : g_rest
        mexp_cell u_cell (
          .clk     (clk),
          .load    (start),
          .shift   (run_r),
          .d_load  (y[gi]),
          .d_shift (ybits[gi-1]),
          .q       (ybits[gi])
        );
      end
    end
  endgenerate

  always_comb begin
    gap_d = m_r - acc_r;
    dbl   = (acc_r >= gap_d) ? (acc_r - gap_d) : (acc_r + acc_r);
    gap_x = m_r - x_r;
    sum   = (dbl >= gap_x) ? (dbl - gap_x) : (dbl + x_r);
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    acc_nxt  = acc_r;
    if (start) begin
      cnt_nxt = CW'(WIDTH);
      run_nxt = 1'b1;
      acc_nxt = '0;
    end else if (run_r) begin
      acc_nxt = ybits[WIDTH-1] ? sum : dbl;
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (start) begin
      x_r <= x;
      m_r <= m;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

[rtl/modular_exponentiation.sv]
// ----------------------------------------------------------------------------
// modular_exponentiation
// Left-to-right square-and-multiply modular exponentiation.
// ----------------------------------------------------------------------------
// One transaction at a time. The base is first reduced by one pass of the
// bit-serial modular multiplier, then each exponent bit below the top set bit
// costs one squaring and, where the bit is one, one more multiplication; the
// top set bit costs one multiplication only. Each multiplier pass walks the
// WIDTH-cell operand chain of y. A zero modulus returns result 0 with
// bad_modulus set.
module modular_exponentiation #(
  parameter int unsigned WIDTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mexp_pkg::mexp_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mexp_pkg::mexp_out_t  out_data
);

  localparam int unsigned CW = $clog2(WIDTH + 1);

  mexp_pkg::mexp_state_t state_r, state_nxt;

  logic [WIDTH-1:0] base_r, base_nxt;
  logic [WIDTH-1:0] exp_r, exp_nxt;
  logic [WIDTH-1:0] mod_r, mod_nxt;
  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [WIDTH-1:0] one_w;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             started_r, started_nxt;
  logic             bad_r, bad_nxt;
  logic             out_valid_r, out_valid_nxt;
  mexp_pkg::mexp_out_t out_r, out_nxt;
  logic [WIDTH-1:0] mm_x, mm_y, mm_prod;
  logic             mm_start, mm_done;
  logic             accept, ebit;
  logic             red_go_r;
  logic             mm_start_w;
  logic [WIDTH-1:0] mm_x_w, mm_y_w;

  assign accept = in_valid && !in_stall;
  assign ebit   = exp_r[WIDTH-1];
  assign one_w  = (mod_r == WIDTH'(1)) ? '0 : WIDTH'(1);

  mexp_modmul #(.WIDTH(WIDTH)) u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mm_start_w),
    .x     (mm_x_w),
    .y     (mm_y_w),
    .m     (mod_r),
    .done  (mm_done),
    .prod  (mm_prod)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mexp_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_data.modulus[WIDTH-1:0] == '0) ? mexp_pkg::ST_DONE
                                                          : mexp_pkg::ST_RED;
        end
      end
      mexp_pkg::ST_RED: begin
        if (mm_done) begin
          state_nxt = mexp_pkg::ST_BIT;
        end
      end
      mexp_pkg::ST_BIT: begin
        if (cnt_r == '0) begin
          state_nxt = mexp_pkg::ST_DONE;
        end else if (started_r) begin
          state_nxt = mexp_pkg::ST_SQ;
        end else if (ebit) begin
          state_nxt = mexp_pkg::ST_ML;
        end
      end
      mexp_pkg::ST_SQ: begin
        if (mm_done) begin
          state_nxt = ebit ? mexp_pkg::ST_ML : mexp_pkg::ST_BIT;
        end
      end
      mexp_pkg::ST_ML: begin
        if (mm_done) begin
          state_nxt = mexp_pkg::ST_BIT;
        end
      end
      mexp_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = mexp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mexp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    base_nxt      = base_r;
    exp_nxt       = exp_r;
    mod_nxt       = mod_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    started_nxt   = started_r;
    bad_nxt       = bad_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    mm_start      = 1'b0;
    mm_x          = one_w;
    mm_y          = base_r;
    unique case (state_r)
      mexp_pkg::ST_IDLE: begin
        if (accept) begin
          base_nxt    = in_data.base[WIDTH-1:0];
          exp_nxt     = in_data.exponent[WIDTH-1:0];
          mod_nxt     = in_data.modulus[WIDTH-1:0];
          bad_nxt     = (in_data.modulus[WIDTH-1:0] == '0);
          cnt_nxt     = CW'(WIDTH);
          started_nxt = 1'b0;
          acc_nxt     = '0;
        end
      end
      mexp_pkg::ST_RED: begin
        if (mm_done) begin
          base_nxt = mm_prod;
          acc_nxt  = one_w;
        end
      end
      mexp_pkg::ST_BIT: begin
        if (cnt_r != '0) begin
          if (started_r) begin
            mm_start = 1'b1;
            mm_x     = acc_r;
            mm_y     = acc_r;
          end else if (ebit) begin
            mm_start = 1'b1;
            mm_x     = acc_r;
            mm_y     = base_r;
          end else begin
            exp_nxt = exp_r << 1;
            cnt_nxt = cnt_r - CW'(1);
          end
        end
      end
      mexp_pkg::ST_SQ: begin
        if (mm_done) begin
          acc_nxt = mm_prod;
          if (ebit) begin
            mm_start = 1'b1;
            mm_x     = mm_prod;
            mm_y     = base_r;
          end else begin
            exp_nxt = exp_r << 1;
            cnt_nxt = cnt_r - CW'(1);
          end
        end
      end
      mexp_pkg::ST_ML: begin
        if (mm_done) begin
          acc_nxt     = mm_prod;
          started_nxt = 1'b1;
          exp_nxt     = exp_r << 1;
          cnt_nxt     = cnt_r - CW'(1);
        end
      end
      mexp_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt       = 1'b1;
          out_nxt.bad_modulus = bad_r;
          out_nxt.result      = bad_r ? '0 : mexp_pkg::FIELD_W'(acc_r);
        end
      end
      default: ;
    endcase
  end

  // start the base reduction on the cycle after accept, once operands are held
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_go_r <= 1'b0;
    end else begin
      red_go_r <= accept && (in_data.modulus[WIDTH-1:0] != '0);
    end
  end

  always_comb begin
    mm_start_w = mm_start | red_go_r;
    mm_x_w     = red_go_r ? one_w : mm_x;
    mm_y_w     = red_go_r ? base_r : mm_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mexp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
      cnt_r       <= '0;
      bad_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      started_r   <= started_nxt;
      cnt_r       <= cnt_nxt;
      bad_r       <= bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    exp_r  <= exp_nxt;
    mod_r  <= mod_nxt;
    acc_r  <= acc_nxt;
    out_r  <= out_nxt;
  end

  assign in_stall  = (state_r != mexp_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[rtl/mexp_checker.sv]
// ----------------------------------------------------------------------------
// mexp_checker
// Port-level checks for the modular exponentiation block.
// ----------------------------------------------------------------------------
module mexp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input mexp_pkg::mexp_in_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input mexp_pkg::mexp_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input transaction changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction taken while busy");

  a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_modulus |-> out_data.result == '0)
    else $error("bad modulus with nonzero result");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[bench/modular_exponentiation_chk.sv]
// ----------------------------------------------------------------------------
// modular_exponentiation_chk
// Watches both channels of the modular exponentiation block, predicts each
// result with its own square-and-multiply model and compares field by field.
// ----------------------------------------------------------------------------
module modular_exponentiation_chk (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  mexp_pkg::mexp_in_t   in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  mexp_pkg::mexp_out_t  out_data,
  output int                   fail_count,
  output int                   pending_count
);

  mexp_pkg::mexp_out_t pending_results[$];

  function automatic logic [63:0] add_mod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    logic [63:0] gap;
    gap = m - y;
    return (x >= gap) ? x - gap : x + y;
  endfunction

  function automatic logic [63:0] mul_mod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    logic [63:0] acc;
    acc = '0;
    for (int i = mexp_pkg::FIELD_W - 1; i >= 0; i--) begin
      acc = add_mod(acc, acc, m);
      if (y[i]) acc = add_mod(acc, x, m);
    end
    return acc;
  endfunction

  function automatic mexp_pkg::mexp_out_t predict_power(mexp_pkg::mexp_in_t t);
    mexp_pkg::mexp_out_t r;
    logic [63:0] b;
    logic [63:0] acc;
    logic started;
    started = 1'b0;
    if (t.modulus == '0) begin
      r.result = '0;
      r.bad_modulus = 1'b1;
      return r;
    end
    b = t.base % t.modulus;
    acc = 64'd1 % t.modulus;
    for (int i = mexp_pkg::FIELD_W - 1; i >= 0; i--) begin
      if (started) acc = mul_mod(acc, acc, t.modulus);
      if (t.exponent[i]) begin
        acc = mul_mod(acc, b, t.modulus);
        started = 1'b1;
      end
    end
    r.result = acc;
    r.bad_modulus = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    mexp_pkg::mexp_out_t exp_r;
    int errs;
    errs = 0;
    if (!rst_n) begin
      fail_count <= 0;
      pending_count <= 0;
    end else begin
      if (in_valid && !in_stall) pending_results.push_back(predict_power(in_data));
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("unexpected transaction result=%h", out_data.result);
          errs++;
        end else begin
          exp_r = pending_results.pop_front();
          if (out_data.result !== exp_r.result) begin
            $error("result expected %h actual %h", exp_r.result, out_data.result);
            errs++;
          end
          if (out_data.bad_modulus !== exp_r.bad_modulus) begin
            $error("bad_modulus expected %b actual %b", exp_r.bad_modulus,
                   out_data.bad_modulus);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending_count <= pending_results.size();
    end
  end
endmodule

[bench/modular_exponentiation_tb.sv]
// ----------------------------------------------------------------------------
// modular_exponentiation_tb
// Drives directed and random base/exponent/modulus transactions through the
// modular exponentiation block under several idle and stall mixes.
// ----------------------------------------------------------------------------
module modular_exponentiation_tb;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  mexp_pkg::mexp_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  mexp_pkg::mexp_out_t out_data;
  int        fail_count;
  int        pending_count;
  int        idle_pct;
  int        stall_pct;
  longint    cycle_count;

  modular_exponentiation #(.WIDTH(64)) uut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  modular_exponentiation_chk chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data), .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 5000000) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] rand_sized();
    int sh;
    sh = $urandom_range(63);
    return rand64() >> sh;
  endfunction

  task automatic send_item(logic [63:0] b, logic [63:0] e, logic [63:0] m);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{base: b, exponent: e, modulus: m};
    do @(posedge clk); while (in_stall);
  endtask

  initial begin
    logic [63:0] m;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    idle_pct = 0;
    stall_pct = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(64'd5, 64'd3, 64'd0);
    send_item('1, '1, 64'd0);
    send_item(64'd7, 64'd0, 64'd13);
    send_item(64'd7, 64'd0, 64'd1);
    send_item(64'd9, 64'd5, 64'd1);
    send_item('1, '1, '1);
    send_item('1, 64'd1, '1);
    send_item('1, '1, 64'hFFFF_FFFF_FFFF_FFC5);
    send_item(64'd0, 64'd5, 64'd97);
    send_item(64'd0, 64'd0, 64'd97);
    send_item(64'd2, 64'd10, 64'd1000);
    send_item(64'd3, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFC5);
    send_item(64'h8000_0000_0000_0001, 64'd2, 64'h8000_0000_0000_0000);
    send_item(64'd123456789, 64'd1, 64'd1000);
    send_item(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 69; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 69; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      for (int i = 0; i < 32; i++) begin
        case ($urandom_range(9))
          0: m = 64'd0;
          1: m = 64'd1;
          2: m = rand64() | 64'h8000_0000_0000_0000;
          default: m = rand_sized();
        endcase
        send_item(($urandom_range(3) == 0) ? '1 : rand64(),
                  ($urandom_range(7) == 0) ? 64'd0 : rand_sized(), m);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

[modular_exponentiation.f]
rtl/mexp_pkg.sv
rtl/mexp_cell.sv
rtl/mexp_modmul.sv
rtl/modular_exponentiation.sv
rtl/mexp_checker.sv
bench/modular_exponentiation_chk.sv
bench/modular_exponentiation_tb.sv
